>>> design/pcsc_pkg.sv
`default_nettype none
// ============================================================================
// pcsc_pkg: shared definitions for the part classify and sort controller
// Event codes, result codes, class and turn codes, register indexes,
// reset values and the fixed constants of the sorting rules.
// ============================================================================
package pcsc_pkg;

   // Queue depth default handed to the top level.
   localparam int QUEUE_DEPTH_DEF = 16;

   // Field widths.
   localparam int ADC_W   = 10;
   localparam int DUTY_W  = 8;
   localparam int STEPS_W = 7;
   localparam int LEVEL_W = 5;
   localparam int COUNT_W = 8;
   localparam int CLASS_W = 2;

   localparam int NUM_CLASSES = 4;
   localparam int NUM_CFG     = 8;
   localparam int CSR_ADDR_W  = 3;

   // Fixed values of the sorting rules.
   localparam logic [ADC_W-1:0]   MIN_RESET     = 10'd1023;
   localparam logic [DUTY_W-1:0]  DUTY_IDLE     = 8'd95;
   localparam logic [DUTY_W-1:0]  DUTY_BUSY     = 8'd220;
   localparam logic [STEPS_W-1:0] QUARTER_STEPS = 7'd50;
   localparam logic [STEPS_W-1:0] HALF_STEPS    = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

   // Event kinds on the request side.
   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_ENTRY  = 2'd1,
      FUNC_EXIT   = 2'd2
   } func_type;

   // Result kinds on the response side.
   typedef enum logic [2:0] {
      KIND_ABSORBED   = 3'd0,
      KIND_QUEUED     = 3'd1,
      KIND_UNMATCHED  = 3'd2,
      KIND_QUEUE_FULL = 3'd3,
      KIND_TRAY_MOVE  = 3'd4,
      KIND_EXIT_EMPTY = 3'd5
   } kind_type;

   // Part classes, in the order the ranges are tested.
   typedef enum logic [CLASS_W-1:0] {
      CLASS_BLACK    = 2'd0,
      CLASS_ALUMINUM = 2'd1,
      CLASS_WHITE    = 2'd2,
      CLASS_STEEL    = 2'd3
   } class_type;

   // Tray turn direction.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLACK_LOW     = 3'd0,
      CSR_BLACK_HIGH    = 3'd1,
      CSR_ALUMINUM_LOW  = 3'd2,
      CSR_ALUMINUM_HIGH = 3'd3,
      CSR_WHITE_LOW     = 3'd4,
      CSR_WHITE_HIGH    = 3'd5,
      CSR_STEEL_LOW     = 3'd6,
      CSR_STEEL_HIGH    = 3'd7
   } csr_idx_type;

   // Reset values of the range registers, by index.
   localparam logic [ADC_W-1:0] CFG_RESET [NUM_CFG] = '{
      10'd949, 10'd1000, 10'd1, 10'd262, 10'd808, 10'd948, 10'd263, 10'd807
   };

endpackage : pcsc_pkg
`default_nettype wire

>>> design/pcsc_ram.sv
`default_nettype none
// ============================================================================
// pcsc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns
// the old contents when the same address is written in the same cycle.
// ============================================================================
module pcsc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : pcsc_ram
`default_nettype wire

>>> design/part_classify_sort_controller_core.sv
`default_nettype none
// ============================================================================
// part_classify_sort_controller_core: sorting conveyor event controller
// Tracks the minimum reflectance of a passing part, classifies it against
// four ranges, queues the class and turns the tray when the part exits.
// ============================================================================
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  ---------------------------------------
//  req      in   req_tvalid/tready    tuser: func; tdata: adc_value, blocked
//  rsp      out  rsp_tvalid/tready    tuser: result_kind; tdata: class..counts
//  csr      in   csr_wr_en            csr_addr, csr_wr_data (no read-back)
//
//  Every event is handled in the cycle it is accepted, and its result is
//  held in the response register from the next cycle on: one beat a cycle while responses drain.
//  The class queue is a RAM whose head entry is prefetched every cycle.
//  A new beat is taken whenever the response register is empty or drains.
//  Reset is synchronous; the queue needs no clearing pass.
//
module part_classify_sort_controller_core
   import pcsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request beats.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // adc_value[9:0], beam_blocked[10]
   input  wire logic [1:0]            req_tuser,   // func[1:0]
   // Response beats.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // part_class[1:0], rotate_dir[3:2], rotate_steps[10:4], queue_level[15:11],
   // motor_duty[23:16], count_black[31:24], count_aluminum[39:32],
   // count_white[47:40], count_steel[55:48]
   output logic      [55:0]           rsp_tdata,
   output logic      [2:0]            rsp_tuser,   // result_kind[2:0]
   // Configuration writes.
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [ADC_W-1:0]      csr_wr_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Registers.
   logic [ADC_W-1:0]   cfg_ff    [NUM_CFG];
   logic [ADC_W-1:0]   min_ff,   min_in;
   logic [PTR_W-1:0]   head_ff,  head_in;
   logic [PTR_W-1:0]   tail_ff,  tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   class_type          tray_ff,  tray_in;
   logic [DUTY_W-1:0]  duty_ff,  duty_in;
   logic [COUNT_W-1:0] cnt_ff    [NUM_CLASSES];
   logic [COUNT_W-1:0] cnt_in    [NUM_CLASSES];
   logic               byp_ff,   byp_in;
   logic [CLASS_W-1:0] byp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           out_kind_ff,  out_kind_in;
   class_type          out_class_ff, out_class_in;
   dir_type            out_dir_ff,   out_dir_in;
   logic [STEPS_W-1:0] out_steps_ff, out_steps_in;

   // Combinational signals.
   logic               accept;
   func_type           func;
   logic [ADC_W-1:0]   adc_value;
   logic               beam_blocked;
   logic [ADC_W-1:0]   min_now;
   logic [NUM_CLASSES-1:0] in_range;
   logic               matched;
   class_type          match_class;
   logic [CLASS_W-1:0] ram_rd_data;
   class_type          head_class;
   logic [1:0]         turn_dist;
   logic               wr_en;

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign func         = func_type'(req_tuser);
   assign adc_value    = req_tdata[ADC_W-1:0];
   assign beam_blocked = req_tdata[ADC_W];

   // Minimum including the current sample.
   assign min_now = (adc_value < min_ff) ? adc_value : min_ff;

   // Range checks, one per class.
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         in_range[c] = (min_now >= cfg_ff[2*c]) && (min_now <= cfg_ff[2*c+1]);
      end
   end

   // First matching range wins, in class order.
   always_comb begin
      matched     = |in_range;
      match_class = CLASS_STEEL;
      if (in_range[CLASS_BLACK]) begin
         match_class = CLASS_BLACK;
      end else if (in_range[CLASS_ALUMINUM]) begin
         match_class = CLASS_ALUMINUM;
      end else if (in_range[CLASS_WHITE]) begin
         match_class = CLASS_WHITE;
      end
   end

   // Head of the queue: the prefetched RAM word, or the word written into
   // the head slot in the previous cycle.
   assign head_class = class_type'(byp_ff ? byp_data_ff : ram_rd_data);
   assign turn_dist  = tray_ff - head_class;

   // Event handling.
   always_comb begin
      min_in       = min_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      tray_in      = tray_ff;
      duty_in      = duty_ff;
      cnt_in       = cnt_ff;
      wr_en        = 1'b0;
      out_kind_in  = KIND_ABSORBED;
      out_class_in = CLASS_BLACK;
      out_dir_in   = DIR_NONE;
      out_steps_in = '0;
      if (accept) begin
         case (func)
            FUNC_ENTRY: begin
               min_in = MIN_RESET;
            end
            FUNC_SAMPLE: begin
               min_in = min_now;
               if (!beam_blocked) begin
                  if (!matched) begin
                     out_kind_in = KIND_UNMATCHED;
                  end else if (count_ff >= CNT_FULL) begin
                     out_kind_in  = KIND_QUEUE_FULL;
                     out_class_in = match_class;
                  end else begin
                     wr_en        = 1'b1;
                     tail_in      = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                     count_in     = count_ff + 1'b1;
                     out_kind_in  = KIND_QUEUED;
                     out_class_in = match_class;
                  end
               end
            end
            FUNC_EXIT: begin
               duty_in = DUTY_BUSY;
               if (count_ff == '0) begin
                  out_kind_in = KIND_EXIT_EMPTY;
               end else begin
                  head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  case (turn_dist)
                     2'd1: begin
                        out_dir_in   = DIR_CCW;
                        out_steps_in = QUARTER_STEPS;
                     end
                     2'd2: begin
                        out_dir_in   = DIR_CW;
                        out_steps_in = HALF_STEPS;
                     end
                     2'd3: begin
                        out_dir_in   = DIR_CW;
                        out_steps_in = QUARTER_STEPS;
                     end
                     default: begin
                        out_dir_in   = DIR_NONE;
                        out_steps_in = '0;
                     end
                  endcase
                  tray_in = head_class;
                  for (int c = 0; c < NUM_CLASSES; c++) begin
                     if ((CLASS_W'(c) == head_class) && (cnt_ff[c] != COUNT_MAX)) begin
                        cnt_in[c] = cnt_ff[c] + 1'b1;
                     end
                  end
                  if (count_ff == CNT_W'(1)) begin
                     duty_in = DUTY_IDLE;
                  end
                  out_kind_in  = KIND_TRAY_MOVE;
                  out_class_in = head_class;
               end
            end
            default: begin
               min_in = min_ff;
            end
         endcase
      end
   end

   // A write into the slot being prefetched is forwarded from the bypass register in the next cycle.
   assign byp_in = wr_en && (tail_ff == head_in);

   // Response register valid.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Class queue storage, read at the next head every cycle.
   pcsc_ram #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (match_class),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
         min_ff       <= MIN_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         tray_ff      <= CLASS_BLACK;
         duty_ff      <= DUTY_IDLE;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            cnt_ff[c] <= '0;
         end
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff[csr_addr] <= csr_wr_data;
         end
         min_ff       <= min_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         tray_ff      <= tray_in;
         duty_ff      <= duty_in;
         cnt_ff       <= cnt_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byp_data_ff <= match_class;
      if (accept) begin
         out_kind_ff  <= out_kind_in;
         out_class_ff <= out_class_in;
         out_dir_ff   <= out_dir_in;
         out_steps_ff <= out_steps_in;
      end
   end

   // Level, duty and counts are state after the event, so they show the
   // registered state directly.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {cnt_ff[CLASS_STEEL], cnt_ff[CLASS_WHITE],
                        cnt_ff[CLASS_ALUMINUM], cnt_ff[CLASS_BLACK],
                        duty_ff, LEVEL_W'(count_ff), out_steps_ff,
                        out_dir_ff, out_class_ff};

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   // A dispatch from a non-empty queue removes exactly one entry.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (func == FUNC_EXIT) && (count_ff != '0))
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("dispatch did not remove one entry");

   // Conveyor duty is only ever the idle or the busy value.
   a_duty_values: assert property (@(posedge clock) disable iff (reset)
      (duty_ff == DUTY_IDLE) || (duty_ff == DUTY_BUSY))
      else $error("unexpected conveyor duty");

   // A held response beat does not change while it waits.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tuser)))
      else $error("response beat changed while stalled");
`endif

endmodule : part_classify_sort_controller_core
`default_nettype wire
